/* design/vcfc_pkg.sv */
package vcfc_pkg;

    // opcodes of an input beat
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_SCAN  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_CHUNK_POS_X = 2'd0;
    localparam logic [1:0] CFG_CHUNK_POS_Z = 2'd1;
    localparam logic [1:0] CFG_VOXEL_SCALE = 2'd2;

    localparam int          CFG_DATA_W     = 16;
    localparam logic [15:0] SCALE_RESET    = 16'd256;

    // block id that lets a face show besides air
    localparam logic [7:0] WATER_ID = 8'd7;
    localparam logic [7:0] AIR_ID   = 8'd0;

    // shared multiplier widths: chunk*size + local fits 26 bits signed
    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic signed [MUL_P_W-1:0] W36_HI = 43'sd34359738367;
    localparam logic signed [MUL_P_W-1:0] W36_LO = -43'sd34359738368;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] pos_z;
        logic [7:0] new_block;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         block_id;
        logic               emitted;
        logic signed [35:0] world_x;
        logic [23:0]        world_y;
        logic signed [35:0] world_z;
        logic               scan_last;
        logic               dirty;
    } out_item_t;

    // operand pair for the shared multiplier
    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } mul_req_t;

    // clamp a product to the signed 36-bit world range
    function automatic logic signed [35:0] sat36(input logic signed [MUL_P_W-1:0] v);
        logic signed [35:0] r;
        if (v > W36_HI)
        begin
            r = W36_HI[35:0];
        end
        else if (v < W36_LO)
        begin
            r = W36_LO[35:0];
        end
        else
        begin
            r = v[35:0];
        end
        return r;
    endfunction

endpackage

/* design/vcfc_ram.sv */
module vcfc_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single port, read data registered and held between reads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/vcfc_mul.sv */
module vcfc_mul
    import vcfc_pkg::*;
(
    input  logic                       clk,
    input  mul_req_t                   req,
    output logic signed [MUL_P_W-1:0]  prod
);

    logic signed [MUL_P_W-1:0] prod_reg;

    // one signed multiply per cycle, product registered
    always_ff @(posedge clk)
    begin
        prod_reg <= MUL_P_W'(req.a) * MUL_P_W'(req.b);
    end

    assign prod = prod_reg;

endmodule

/* design/voxel_chunk_face_cull.sv */
// voxel chunk store with hidden-face culling scan
// input channel in_valid/in_stall/in_data carries write, read and scan-step beats;
// output channel out_valid/out_stall/out_data carries one result for each read
// and each scan step, none for a write or an unused opcode.
// the user is to write the configuration port (cfg_we, cfg_index, cfg_data) while
// idle; the block itself does not enforce it. one item is handled at a time:
// a write goes through S_WRITE, a read through S_READ, which reads the store,
// and S_RRESP, which loads the output register; a scan step runs through the
// S_SCAN steps up to ST_LAST, which loads it. the length of a scan step is set by
// the single store port: the centre and its six neighbours are read one per
// cycle, while the shared multiplier forms the world coordinates meanwhile.
// the output register lets the next beat be accepted while a result waits;
// when the receiver stalls, a finished read or scan step waits in its last state
// until the output register is free.
// after reset the store is swept to air, one entry per cycle, over all
// 2**(clog2(SIZE_X)+clog2(SIZE_Y)+clog2(SIZE_Z)) entries (4096 at 16x16x16);
// in_stall stays high meanwhile, configuration writes are still taken.
module voxel_chunk_face_cull
    import vcfc_pkg::*;
#(
    parameter int SIZE_X = 16,
    parameter int SIZE_Y = 16,
    parameter int SIZE_Z = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int WX     = $clog2(SIZE_X);
    localparam int WY     = $clog2(SIZE_Y);
    localparam int WZ     = $clog2(SIZE_Z);
    localparam int ADDR_W = WX + WY + WZ;
    localparam int DEPTH  = 1 << ADDR_W;

    // sequence steps of a scan
    localparam logic [2:0] ST_CENTRE = 3'd0;
    localparam logic [2:0] ST_ZM     = 3'd1;
    localparam logic [2:0] ST_ZP     = 3'd2;
    localparam logic [2:0] ST_XM     = 3'd3;
    localparam logic [2:0] ST_XP     = 3'd4;
    localparam logic [2:0] ST_YM     = 3'd5;
    localparam logic [2:0] ST_YP     = 3'd6;
    localparam logic [2:0] ST_LAST   = 3'd7;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_WRITE = 6'b000100,
        S_READ  = 6'b001000,
        S_RRESP = 6'b010000,
        S_SCAN  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]      clr_addr_reg;
    logic [2:0]             step_reg;
    logic [7:0]             pos_x_reg, pos_y_reg, pos_z_reg, new_block_reg;
    logic [WX-1:0]          sx_reg;
    logic [WY-1:0]          sy_reg;
    logic [WZ-1:0]          sz_reg;
    logic                   dirty_reg;
    logic signed [15:0]     chunk_x_reg, chunk_z_reg;
    logic [15:0]            scale_reg;
    logic [7:0]             centre_reg;
    logic                   open_reg;
    logic                   outside_reg;
    logic signed [35:0]     wx_reg, wz_reg;
    logic [23:0]            wy_reg;
    logic                   out_valid_reg;
    out_item_t              out_reg;

    logic                   in_accept;
    logic                   out_free;
    logic                   out_load;
    out_item_t              out_next;
    logic                   item_in_range;
    logic [ADDR_W-1:0]      item_addr;
    logic [WX-1:0]          nb_x;
    logic [WY-1:0]          nb_y;
    logic [WZ-1:0]          nb_z;
    logic                   nb_outside;
    logic                   cur_open;
    logic                   scan_last;
    logic                   emit;
    logic                   ram_en, ram_we;
    logic [ADDR_W-1:0]      ram_addr;
    logic [7:0]             ram_wdata, ram_rdata;
    mul_req_t               mul_req;
    logic signed [MUL_P_W-1:0] prod;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // position check and store address of the held item
    assign item_in_range = ({1'b0, pos_x_reg} < 9'(SIZE_X))
                        && ({1'b0, pos_y_reg} < 9'(SIZE_Y))
                        && ({1'b0, pos_z_reg} < 9'(SIZE_Z));
    assign item_addr = {pos_x_reg[WX-1:0], pos_y_reg[WY-1:0], pos_z_reg[WZ-1:0]};

    // neighbour chosen by the scan step
    always_comb
    begin
        nb_x       = sx_reg;
        nb_y       = sy_reg;
        nb_z       = sz_reg;
        nb_outside = 1'b0;
        unique case (step_reg)
            ST_ZM:
            begin
                nb_z       = sz_reg - 1'b1;
                nb_outside = (sz_reg == '0);
            end
            ST_ZP:
            begin
                nb_z       = sz_reg + 1'b1;
                nb_outside = (sz_reg == WZ'(SIZE_Z - 1));
            end
            ST_XM:
            begin
                nb_x       = sx_reg - 1'b1;
                nb_outside = (sx_reg == '0);
            end
            ST_XP:
            begin
                nb_x       = sx_reg + 1'b1;
                nb_outside = (sx_reg == WX'(SIZE_X - 1));
            end
            ST_YM:
            begin
                nb_y       = sy_reg - 1'b1;
                nb_outside = (sy_reg == '0);
            end
            ST_YP:
            begin
                nb_y       = sy_reg + 1'b1;
                nb_outside = (sy_reg == WY'(SIZE_Y - 1));
            end
            default:
            begin
                nb_outside = 1'b0;
            end
        endcase
    end

    // store port use by state
    always_comb
    begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = item_addr;
        ram_wdata = new_block_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = clr_addr_reg;
                ram_wdata = AIR_ID;
            end
            S_WRITE:
            begin
                ram_en = item_in_range;
                ram_we = 1'b1;
            end
            S_READ:
            begin
                ram_en = 1'b1;
            end
            S_SCAN:
            begin
                ram_en   = (step_reg != ST_LAST);
                ram_addr = {nb_x, nb_y, nb_z};
            end
            default:
            begin
                ram_en = 1'b0;
            end
        endcase
    end

    vcfc_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // multiplier operands: base = chunk*size + local, then base*scale; y is local*scale
    always_comb
    begin
        mul_req.a = '0;
        mul_req.b = '0;
        unique case (step_reg)
            ST_CENTRE:
            begin
                mul_req.a = MUL_A_W'(chunk_x_reg);
                mul_req.b = MUL_B_W'(SIZE_X);
            end
            ST_ZM:
            begin
                mul_req.a = signed'(prod[MUL_A_W-1:0] + MUL_A_W'(sx_reg));
                mul_req.b = signed'({1'b0, scale_reg});
            end
            ST_ZP:
            begin
                mul_req.a = MUL_A_W'(chunk_z_reg);
                mul_req.b = MUL_B_W'(SIZE_Z);
            end
            ST_XM:
            begin
                mul_req.a = signed'(prod[MUL_A_W-1:0] + MUL_A_W'(sz_reg));
                mul_req.b = signed'({1'b0, scale_reg});
            end
            ST_XP:
            begin
                mul_req.a = signed'(MUL_A_W'(sy_reg));
                mul_req.b = signed'({1'b0, scale_reg});
            end
            default:
            begin
                mul_req.a = '0;
                mul_req.b = '0;
            end
        endcase
    end

    vcfc_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    // visibility of the face whose data arrives this cycle
    assign cur_open  = outside_reg || (ram_rdata == AIR_ID) || (ram_rdata == WATER_ID);
    assign emit      = (centre_reg != AIR_ID) && (open_reg || cur_open);
    assign scan_last = (sx_reg == WX'(SIZE_X - 1)) && (sy_reg == WY'(SIZE_Y - 1))
                    && (sz_reg == WZ'(SIZE_Z - 1));

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    priority if (in_data.opcode == OP_WRITE)
                    begin
                        state_next = S_WRITE;
                    end
                    else if (in_data.opcode == OP_READ)
                    begin
                        state_next = S_READ;
                    end
                    else if (in_data.opcode == OP_SCAN)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_WRITE:
            begin
                state_next = S_IDLE;
            end
            S_READ:
            begin
                state_next = S_RRESP;
            end
            S_RRESP:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (step_reg == ST_LAST && out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result beat
    always_comb
    begin
        out_next = '0;
        if (state_reg == S_RRESP)
        begin
            out_next.block_id = item_in_range ? ram_rdata : AIR_ID;
            out_next.dirty    = dirty_reg;
        end
        else
        begin
            out_next.block_id  = centre_reg;
            out_next.emitted   = emit;
            out_next.world_x   = emit ? wx_reg : '0;
            out_next.world_y   = emit ? wy_reg : '0;
            out_next.world_z   = emit ? wz_reg : '0;
            out_next.scan_last = scan_last;
            out_next.dirty     = dirty_reg && !scan_last;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            step_reg      <= ST_CENTRE;
            sx_reg        <= '0;
            sy_reg        <= '0;
            sz_reg        <= '0;
            dirty_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
            chunk_x_reg   <= '0;
            chunk_z_reg   <= '0;
            scale_reg     <= SCALE_RESET;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == S_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end

            // configuration writes
            if (cfg_we)
            begin
                priority if (cfg_index == CFG_CHUNK_POS_X)
                begin
                    chunk_x_reg <= signed'(cfg_data);
                end
                else if (cfg_index == CFG_CHUNK_POS_Z)
                begin
                    chunk_z_reg <= signed'(cfg_data);
                end
                else if (cfg_index == CFG_VOXEL_SCALE)
                begin
                    scale_reg <= cfg_data;
                end
            end

            // scan step counter
            if (state_reg == S_IDLE)
            begin
                step_reg <= ST_CENTRE;
            end
            else if (state_reg == S_SCAN && step_reg != ST_LAST)
            begin
                step_reg <= step_reg + 1'b1;
            end

            if (state_reg == S_WRITE && item_in_range)
            begin
                dirty_reg <= 1'b1;
            end

            // advance the scan position, z innermost
            if (state_reg == S_SCAN && out_load)
            begin
                if (scan_last)
                begin
                    dirty_reg <= 1'b0;
                end
                if (sz_reg == WZ'(SIZE_Z - 1))
                begin
                    sz_reg <= '0;
                    if (sy_reg == WY'(SIZE_Y - 1))
                    begin
                        sy_reg <= '0;
                        if (sx_reg == WX'(SIZE_X - 1))
                        begin
                            sx_reg <= '0;
                        end
                        else
                        begin
                            sx_reg <= sx_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        sy_reg <= sy_reg + 1'b1;
                    end
                end
                else
                begin
                    sz_reg <= sz_reg + 1'b1;
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pos_x_reg     <= in_data.pos_x;
            pos_y_reg     <= in_data.pos_y;
            pos_z_reg     <= in_data.pos_z;
            new_block_reg <= in_data.new_block;
        end

        if (state_reg == S_SCAN)
        begin
            if (ram_en)
            begin
                outside_reg <= nb_outside;
            end
            // collect the centre id and the neighbour faces
            if (step_reg == ST_ZM)
            begin
                centre_reg <= ram_rdata;
                open_reg   <= 1'b0;
            end
            else if (step_reg != ST_CENTRE && step_reg != ST_LAST)
            begin
                open_reg <= open_reg || cur_open;
            end
            // capture the world coordinates off the multiplier
            if (step_reg == ST_ZP)
            begin
                wx_reg <= sat36(prod);
            end
            if (step_reg == ST_XP)
            begin
                wz_reg <= sat36(prod);
            end
            if (step_reg == ST_YM)
            begin
                wy_reg <= prod[23:0];
            end
        end

        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* dv/tb_voxel_chunk_face_cull.sv */
module tb_voxel_chunk_face_cull;
    import vcfc_pkg::*;

    localparam int     CLK_PERIOD     = 12;
    localparam int     RESET_CYCLES   = 9;
    localparam int     CHUNK_X        = 16;
    localparam int     CHUNK_Y        = 16;
    localparam int     CHUNK_Z        = 16;
    localparam int     VOLUME         = CHUNK_X * CHUNK_Y * CHUNK_Z;
    localparam int     RANDOM_BEATS   = 100;
    localparam int     NUM_PHASES     = 5;
    localparam int     SETTLE_CYCLES  = 24;
    localparam int     LONG_HOLD      = 400;
    localparam longint TIMEOUT_CYCLES = 300000;
    localparam longint WORLD_MAX      = 64'sd34359738367;
    localparam longint WORLD_MIN      = -64'sd34359738368;

    // opcode that the block drops without a result
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // expected results of the voxel store and its culling scan
    class cull_scoreboard;
        logic [7:0]         voxels [VOLUME];
        bit                 dirty_flag;
        int                 scan_pos;
        logic signed [15:0] chunk_x;
        logic signed [15:0] chunk_z;
        logic [15:0]        scale;
        int                 errors;
        out_item_t          awaited_results [$];

        function new();
            foreach (voxels[i])
            begin
                voxels[i] = AIR_ID;
            end
            dirty_flag = 1'b1;
            scan_pos   = 0;
            chunk_x    = '0;
            chunk_z    = '0;
            scale      = SCALE_RESET;
            errors     = 0;
        endfunction

        function bit in_bounds(int x, int y, int z);
            return x >= 0 && x < CHUNK_X && y >= 0 && y < CHUNK_Y && z >= 0 && z < CHUNK_Z;
        endfunction

        function int slot(int x, int y, int z);
            return x + y * CHUNK_X + z * CHUNK_X * CHUNK_Y;
        endfunction

        // a face shows towards the outside, air or water
        function bit face_open(int x, int y, int z);
            logic [7:0] id;
            if (!in_bounds(x, y, z))
            begin
                return 1'b1;
            end
            id = voxels[slot(x, y, z)];
            return id == AIR_ID || id == WATER_ID;
        endfunction

        function logic signed [35:0] world_coord(logic signed [15:0] chunk, int span, int offset);
            longint w;
            w = (longint'(chunk) * span + offset) * longint'(scale);
            if (w > WORLD_MAX)
            begin
                w = WORLD_MAX;
            end
            else if (w < WORLD_MIN)
            begin
                w = WORLD_MIN;
            end
            return w[35:0];
        endfunction

        function void set_register(logic [1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_CHUNK_POS_X: chunk_x = data;
                CFG_CHUNK_POS_Z: chunk_z = data;
                CFG_VOXEL_SCALE: scale   = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        // apply an accepted input beat and queue the result it causes
        function void note_input(in_item_t beat);
            out_item_t  r;
            int         x;
            int         y;
            int         z;
            logic [7:0] id;
            longint     wy;
            r = '0;
            x = int'(beat.pos_x);
            y = int'(beat.pos_y);
            z = int'(beat.pos_z);
            case (beat.opcode)
                OP_WRITE:
                begin
                    if (in_bounds(x, y, z))
                    begin
                        voxels[slot(x, y, z)] = beat.new_block;
                        dirty_flag = 1'b1;
                    end
                end
                OP_READ:
                begin
                    if (in_bounds(x, y, z))
                    begin
                        r.block_id = voxels[slot(x, y, z)];
                    end
                    r.dirty = dirty_flag;
                    awaited_results.push_back(r);
                end
                OP_SCAN:
                begin
                    // x outermost, z innermost
                    z  = scan_pos % CHUNK_Z;
                    y  = (scan_pos / CHUNK_Z) % CHUNK_Y;
                    x  = scan_pos / (CHUNK_Z * CHUNK_Y);
                    id = voxels[slot(x, y, z)];
                    r.block_id = id;
                    if (id != AIR_ID &&
                        (face_open(x, y, z - 1) || face_open(x, y, z + 1) ||
                         face_open(x - 1, y, z) || face_open(x + 1, y, z) ||
                         face_open(x, y - 1, z) || face_open(x, y + 1, z)))
                    begin
                        wy        = longint'(y) * longint'(scale);
                        r.emitted = 1'b1;
                        r.world_x = world_coord(chunk_x, CHUNK_X, x);
                        r.world_y = wy[23:0];
                        r.world_z = world_coord(chunk_z, CHUNK_Z, z);
                    end
                    if (scan_pos == VOLUME - 1)
                    begin
                        dirty_flag  = 1'b0;
                        scan_pos    = 0;
                        r.scan_last = 1'b1;
                    end
                    else
                    begin
                        scan_pos++;
                    end
                    r.dirty = dirty_flag;
                    awaited_results.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got)
            begin
                errors++;
                $error("%s: expected %0d, actual %0d", name, want, got);
            end
        endfunction

        // compare an accepted result beat with the oldest expectation
        function void check_result(out_item_t got);
            out_item_t want;
            if (awaited_results.size() == 0)
            begin
                errors++;
                $error("result beat with no expectation waiting");
                return;
            end
            want = awaited_results.pop_front();
            compare_field("block_id", longint'(want.block_id), longint'(got.block_id));
            compare_field("emitted", longint'(want.emitted), longint'(got.emitted));
            compare_field("world_x", longint'(want.world_x), longint'(got.world_x));
            compare_field("world_y", longint'(want.world_y), longint'(got.world_y));
            compare_field("world_z", longint'(want.world_z), longint'(got.world_z));
            compare_field("scan_last", longint'(want.scan_last), longint'(got.scan_last));
            compare_field("dirty", longint'(want.dirty), longint'(got.dirty));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_data;
    logic                  cfg_we;
    logic [1:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cull_scoreboard sb;

    // idle pattern state of each side
    int sender_run = 0;
    bit sender_busy = 1'b0;
    int sink_run = 0;
    bit sink_busy = 1'b0;

    voxel_chunk_face_cull #(
        .SIZE_X (CHUNK_X),
        .SIZE_Y (CHUNK_Y),
        .SIZE_Z (CHUNK_Z)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // stretches of busy idling are mixed at random with stretches of none
    function automatic int draw_gap(inout int run_left, inout bit busy);
        if (run_left == 0)
        begin
            run_left = $urandom_range(8, 40);
            busy     = ($urandom_range(0, 2) != 0);
        end
        run_left--;
        return busy ? $urandom_range(0, 14) : 0;
    endfunction

    function automatic in_item_t make_beat(logic [1:0] op, logic [7:0] x, logic [7:0] y,
                                           logic [7:0] z, logic [7:0] id);
        in_item_t b;
        b.opcode    = op;
        b.pos_x     = x;
        b.pos_y     = y;
        b.pos_z     = z;
        b.new_block = id;
        return b;
    endfunction

    // scan step with junk in the unused fields
    function automatic in_item_t scan_beat();
        return make_beat(OP_SCAN, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    // most positions cluster in a small cube so that hidden voxels build up
    function automatic in_item_t random_beat();
        in_item_t b;
        int       pick;
        b    = scan_beat();
        pick = $urandom_range(0, 19);
        if (pick < 9)
        begin
            b.opcode = OP_WRITE;
        end
        else if (pick < 13)
        begin
            b.opcode = OP_READ;
        end
        else if (pick == 19)
        begin
            b.opcode = OP_UNUSED;
        end
        pick = $urandom_range(0, 19);
        if (pick < 12)
        begin
            b.pos_x = 8'($urandom_range(3, 8));
            b.pos_y = 8'($urandom_range(3, 8));
            b.pos_z = 8'($urandom_range(3, 8));
        end
        else if (pick < 17)
        begin
            b.pos_x = 8'($urandom_range(0, CHUNK_X - 1));
            b.pos_y = 8'($urandom_range(0, CHUNK_Y - 1));
            b.pos_z = 8'($urandom_range(0, CHUNK_Z - 1));
        end
        case ($urandom_range(0, 9))
            0:       b.new_block = AIR_ID;
            1:       b.new_block = WATER_ID;
            2:       b.new_block = 8'hFF;
            default: b.new_block = 8'($urandom_range(1, 255));
        endcase
        return b;
    endfunction

    // offer one beat and hold it until taken
    task automatic send_beat(input in_item_t beat);
        int gap;
        gap = draw_gap(sender_run, sender_busy);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(beat);
    endtask

    // wait until every result is in and the block has gone quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_registers(input logic [15:0] pos_x, input logic [15:0] pos_z,
                                     input logic [15:0] scale);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CHUNK_POS_X;
        cfg_data  <= pos_x;
        @(posedge clk);
        cfg_index <= CFG_VOXEL_SCALE;
        cfg_data  <= scale;
        @(posedge clk);
        cfg_index <= CFG_CHUNK_POS_Z;
        cfg_data  <= pos_z;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_register(CFG_CHUNK_POS_X, pos_x);
        sb.set_register(CFG_CHUNK_POS_Z, pos_z);
        sb.set_register(CFG_VOXEL_SCALE, scale);
    endtask

    task automatic run_random(input int count);
        in_item_t b;
        int       n;
        n = 0;
        while (n < count)
        begin
            b = random_beat();
            send_beat(b);
            if (b.opcode != OP_UNUSED)
            begin
                n++;
            end
        end
    endtask

    task automatic run_directed();
        // reset contents and first scan step
        send_beat(make_beat(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0));
        send_beat(scan_beat());
        // corners, id extremes, just and far out of range
        send_beat(make_beat(OP_WRITE, 8'd0, 8'd0, 8'd0, 8'hFF));
        send_beat(make_beat(OP_WRITE, 8'd15, 8'd15, 8'd15, 8'd1));
        send_beat(make_beat(OP_WRITE, 8'd255, 8'd255, 8'd255, 8'h5A));
        send_beat(make_beat(OP_WRITE, 8'd16, 8'd0, 8'd0, 8'd3));
        send_beat(make_beat(OP_WRITE, 8'd0, 8'd16, 8'd0, 8'd3));
        send_beat(make_beat(OP_WRITE, 8'd0, 8'd0, 8'd16, 8'd3));
        send_beat(make_beat(OP_READ, 8'd255, 8'd255, 8'd255, 8'hFF));
        send_beat(make_beat(OP_READ, 8'd16, 8'd0, 8'd0, 8'd0));
        send_beat(make_beat(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0));
        send_beat(make_beat(OP_READ, 8'd15, 8'd15, 8'd15, 8'd0));
        // water is solid for itself but open for its neighbours
        send_beat(make_beat(OP_WRITE, 8'd0, 8'd0, 8'd1, WATER_ID));
        send_beat(make_beat(OP_READ, 8'd0, 8'd0, 8'd1, 8'd0));
        send_beat(make_beat(OP_UNUSED, 8'd255, 8'd255, 8'd255, 8'hFF));
        send_beat(scan_beat());
        // fully enclosed voxel
        send_beat(make_beat(OP_WRITE, 8'd5, 8'd5, 8'd5, 8'h80));
        send_beat(make_beat(OP_WRITE, 8'd4, 8'd5, 8'd5, 8'd2));
        send_beat(make_beat(OP_WRITE, 8'd6, 8'd5, 8'd5, 8'd2));
        send_beat(make_beat(OP_WRITE, 8'd5, 8'd4, 8'd5, 8'd2));
        send_beat(make_beat(OP_WRITE, 8'd5, 8'd6, 8'd5, 8'd2));
        send_beat(make_beat(OP_WRITE, 8'd5, 8'd5, 8'd4, 8'd2));
        send_beat(make_beat(OP_WRITE, 8'd5, 8'd5, 8'd6, 8'd2));
        send_beat(scan_beat());
    endtask

    // result side: draws a stall per beat, with an occasional long hold-off
    initial
    begin : result_sink
        int hold;
        int taken;
        hold  = 0;
        taken = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                sb.check_result(out_data);
                taken++;
                if (taken % 1500 == 150)
                begin
                    hold = LONG_HOLD;
                end
                else
                begin
                    hold = draw_gap(sink_run, sink_busy);
                end
            end
            else if (out_valid && hold > 0)
            begin
                hold--;
            end
            out_stall <= (hold > 0);
        end
    end

    // main sequence
    initial
    begin : stimulus
        logic [15:0] set_x [NUM_PHASES];
        logic [15:0] set_z [NUM_PHASES];
        logic [15:0] set_s [NUM_PHASES];
        sb = new();
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_CHUNK_POS_X;
        cfg_data  <= '0;
        // phase 0 runs on reset values, the rest on extremes and one random set
        set_x = '{16'h0000, 16'h7FFF, 16'h8000, 16'h8000, 16'($urandom)};
        set_z = '{16'h0000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'($urandom)};
        set_s = '{SCALE_RESET, 16'hFFFF, 16'h0000, 16'hFFFF, 16'($urandom)};
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase > 0)
            begin
                settle();
                program_registers(set_x[phase], set_z[phase], set_s[phase]);
            end
            run_random(RANDOM_BEATS);
        end
        settle();
        @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // hang guard
    initial
    begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
